FILE: hw/rtl/twsa_pkg.sv
// shared types and constants of the two-wire status and address unit
package twsa_pkg;

  // event codes carried in the action field of a request
  typedef enum logic [3:0] {
    ACT_CTRL_WRITE     = 4'd0,
    ACT_DATA_WRITE     = 4'd1,
    ACT_HOST_START     = 4'd2,
    ACT_HOST_STANDBY   = 4'd3,
    ACT_HOST_RX        = 4'd4,
    ACT_ARB_LOST       = 4'd5,
    ACT_CLIENT_ADDR    = 4'd6,
    ACT_CLIENT_STANDBY = 4'd7,
    ACT_CLIENT_RX      = 4'd8,
    ACT_ACK_SENT       = 4'd9,
    ACT_ACK_RCVD       = 4'd10,
    ACT_START_STOP     = 4'd11
  } action_t;

  // configuration register indexes
  localparam logic [1:0] CFG_OWN_ADDRESS  = 2'd0;
  localparam logic [1:0] CFG_ADDRESS_MASK = 2'd1;
  localparam logic [1:0] CFG_GC_ENABLE    = 2'd2;

  // status codes, bus status shifted right by three
  localparam logic [4:0] ST_HOST_START        = 5'd1;
  localparam logic [4:0] ST_HOST_AW_ACK       = 5'd3;
  localparam logic [4:0] ST_HOST_AW_NACK      = 5'd4;
  localparam logic [4:0] ST_HOST_DW_ACK       = 5'd5;
  localparam logic [4:0] ST_HOST_DW_NACK      = 5'd6;
  localparam logic [4:0] ST_HOST_ARB_LOST     = 5'd7;
  localparam logic [4:0] ST_HOST_AR_ACK       = 5'd8;
  localparam logic [4:0] ST_HOST_AR_NACK      = 5'd9;
  localparam logic [4:0] ST_HOST_DR_ACK       = 5'd10;
  localparam logic [4:0] ST_HOST_DR_NACK      = 5'd11;
  localparam logic [4:0] ST_CL_AW             = 5'd12;
  localparam logic [4:0] ST_CL_AW_AL          = 5'd13;
  localparam logic [4:0] ST_CL_GC             = 5'd14;
  localparam logic [4:0] ST_CL_GC_AL          = 5'd15;
  localparam logic [4:0] ST_CL_DATA_ACK       = 5'd16;
  localparam logic [4:0] ST_CL_DATA_NACK      = 5'd17;
  localparam logic [4:0] ST_CL_GC_DATA_ACK    = 5'd18;
  localparam logic [4:0] ST_CL_GC_DATA_NACK   = 5'd19;
  localparam logic [4:0] ST_CL_STOP_RESTART   = 5'd20;
  localparam logic [4:0] ST_CL_AR             = 5'd21;
  localparam logic [4:0] ST_CL_AR_AL          = 5'd22;
  localparam logic [4:0] ST_CL_TX_ACK         = 5'd23;
  localparam logic [4:0] ST_CL_TX_NACK        = 5'd24;
  localparam logic [4:0] ST_CL_TX_LAST_ACK    = 5'd25;
  localparam logic [4:0] ST_NO_STATE          = 5'd31;

  localparam logic [6:0] OWN_ADDRESS_RESET = 7'h7F;
  localparam logic [7:0] DATA_RESET        = 8'hFF;

  typedef struct packed {
    logic [6:0] own_address;
    logic [6:0] address_mask;
    logic       general_call_enable;
  } cfg_t;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] byte_value;
    logic       first_byte;
    logic       read_not_write;
    logic       ack_bit;
    logic       host_lost_arbitration;
    logic       enable_bit;
    logic       flag_clear_bit;
    logic       ack_enable_bit;
    logic       start_bit;
    logic       stop_bit;
    logic       was_addressed;
  } item_t;

  typedef struct packed {
    logic [4:0] status;
    logic       flag;
    logic [7:0] data;
    logic       ack_enable;
    logic       latched_ack;
    logic       general_call_seen;
    logic       enabled;
  } state_t;

  typedef struct packed {
    logic [4:0] status_code;
    logic       interrupt_flag;
    logic [7:0] data_byte;
    logic       ack_reply;
    logic       command_valid;
    logic       command_start;
    logic       command_stop;
  } result_t;

  // outcome of the own-address compare
  typedef struct packed {
    logic hit;
    logic general_call;
  } match_t;

endpackage

FILE: hw/rtl/twsa_req_if.sv
// request channel of the two-wire status and address unit
interface twsa_req_if;
  logic       valid;
  logic       ready;
  logic [3:0] action;
  logic [7:0] byte_value;
  logic       first_byte;
  logic       read_not_write;
  logic       ack_bit;
  logic       host_lost_arbitration;
  logic       enable_bit;
  logic       flag_clear_bit;
  logic       ack_enable_bit;
  logic       start_bit;
  logic       stop_bit;
  logic       was_addressed;

  modport source (
    output valid, action, byte_value, first_byte, read_not_write, ack_bit,
           host_lost_arbitration, enable_bit, flag_clear_bit, ack_enable_bit,
           start_bit, stop_bit, was_addressed,
    input  ready
  );

  modport sink (
    input  valid, action, byte_value, first_byte, read_not_write, ack_bit,
           host_lost_arbitration, enable_bit, flag_clear_bit, ack_enable_bit,
           start_bit, stop_bit, was_addressed,
    output ready
  );
endinterface

FILE: hw/rtl/twsa_rsp_if.sv
// result channel of the two-wire status and address unit
interface twsa_rsp_if;
  logic       valid;
  logic       ready;
  logic [4:0] status_code;
  logic       interrupt_flag;
  logic [7:0] data_byte;
  logic       ack_reply;
  logic       command_valid;
  logic       command_start;
  logic       command_stop;

  modport source (
    output valid, status_code, interrupt_flag, data_byte, ack_reply,
           command_valid, command_start, command_stop,
    input  ready
  );

  modport sink (
    input  valid, status_code, interrupt_flag, data_byte, ack_reply,
           command_valid, command_start, command_stop,
    output ready
  );
endinterface

FILE: hw/rtl/twsa_addr_match.sv
// own-address and general-call compare for a received address byte
module twsa_addr_match (
  input  logic             [7:0] addr_rw,
  input  twsa_pkg::cfg_t         cfg,
  output twsa_pkg::match_t       match
);

  logic [6:0] addr;

  assign addr = addr_rw[7:1];

  always_comb begin
    match.general_call = (addr_rw == 8'h00) && cfg.general_call_enable;
    match.hit = match.general_call ||
                ((cfg.own_address | cfg.address_mask) == (addr | cfg.address_mask));
  end

endmodule

FILE: hw/rtl/twsa_event_logic.sv
// next state and result for one event
module twsa_event_logic (
  input  twsa_pkg::state_t  st,
  input  twsa_pkg::item_t   item,
  input  twsa_pkg::match_t  match,
  output twsa_pkg::state_t  st_next,
  output twsa_pkg::result_t res
);

  logic       cleared;
  logic       raise;
  logic [4:0] code;

  always_comb begin
    st_next = st;
    res     = '0;
    cleared = 1'b0;
    raise   = 1'b0;
    code    = twsa_pkg::ST_NO_STATE;

    case (twsa_pkg::action_t'(item.action))
      twsa_pkg::ACT_CTRL_WRITE: begin
        st_next.enabled    = item.enable_bit;
        st_next.ack_enable = item.ack_enable_bit;
        cleared = ~st.flag;
        if (item.flag_clear_bit) begin
          st_next.status = twsa_pkg::ST_NO_STATE;
          st_next.flag   = 1'b0;
          cleared        = 1'b1;
        end
        if (item.enable_bit && cleared) begin
          st_next.latched_ack = item.ack_enable_bit;
          res.command_valid   = 1'b1;
          res.command_stop    = item.stop_bit;
          res.command_start   = item.start_bit & ~item.stop_bit;
        end
      end
      twsa_pkg::ACT_DATA_WRITE: begin
        if (st.flag) st_next.data = item.byte_value;
      end
      twsa_pkg::ACT_HOST_START: begin
        raise = 1'b1;
        code  = twsa_pkg::ST_HOST_START;
      end
      twsa_pkg::ACT_HOST_STANDBY: begin
        raise = 1'b1;
        if (item.first_byte) begin
          if (item.read_not_write)
            code = item.ack_bit ? twsa_pkg::ST_HOST_AR_ACK : twsa_pkg::ST_HOST_AR_NACK;
          else
            code = item.ack_bit ? twsa_pkg::ST_HOST_AW_ACK : twsa_pkg::ST_HOST_AW_NACK;
        end else begin
          if (item.read_not_write)
            code = item.ack_bit ? twsa_pkg::ST_HOST_DR_ACK : twsa_pkg::ST_HOST_DR_NACK;
          else
            code = item.ack_bit ? twsa_pkg::ST_HOST_DW_ACK : twsa_pkg::ST_HOST_DW_NACK;
        end
      end
      twsa_pkg::ACT_HOST_RX: begin
        st_next.data  = item.byte_value;
        res.ack_reply = st.ack_enable;
      end
      twsa_pkg::ACT_ARB_LOST: begin
        raise = 1'b1;
        code  = twsa_pkg::ST_HOST_ARB_LOST;
      end
      twsa_pkg::ACT_CLIENT_ADDR: begin
        // compare result is not used while acks are disabled
        if (st.ack_enable) begin
          st_next.general_call_seen = match.general_call;
          res.ack_reply             = match.hit;
        end
      end
      twsa_pkg::ACT_CLIENT_STANDBY: begin
        if (item.first_byte) begin
          raise = 1'b1;
          if (item.read_not_write)
            code = item.host_lost_arbitration ? twsa_pkg::ST_CL_AR_AL : twsa_pkg::ST_CL_AR;
          else if (st.general_call_seen)
            code = item.host_lost_arbitration ? twsa_pkg::ST_CL_GC_AL : twsa_pkg::ST_CL_GC;
          else
            code = item.host_lost_arbitration ? twsa_pkg::ST_CL_AW_AL : twsa_pkg::ST_CL_AW;
        end
      end
      twsa_pkg::ACT_CLIENT_RX: begin
        st_next.data  = item.byte_value;
        res.ack_reply = st.latched_ack;
      end
      twsa_pkg::ACT_ACK_SENT: begin
        raise = 1'b1;
        if (st.general_call_seen)
          code = st.latched_ack ? twsa_pkg::ST_CL_GC_DATA_ACK : twsa_pkg::ST_CL_GC_DATA_NACK;
        else
          code = st.latched_ack ? twsa_pkg::ST_CL_DATA_ACK : twsa_pkg::ST_CL_DATA_NACK;
      end
      twsa_pkg::ACT_ACK_RCVD: begin
        raise = 1'b1;
        if (!item.ack_bit)
          code = twsa_pkg::ST_CL_TX_NACK;
        else if (st.latched_ack)
          code = twsa_pkg::ST_CL_TX_ACK;
        else
          code = twsa_pkg::ST_CL_TX_LAST_ACK;
      end
      twsa_pkg::ACT_START_STOP: begin
        if (item.was_addressed) begin
          raise = 1'b1;
          code  = twsa_pkg::ST_CL_STOP_RESTART;
        end
      end
      default: begin
      end
    endcase

    // status only loads over "no state", flag sets regardless
    if (raise) begin
      if (st.status == twsa_pkg::ST_NO_STATE) st_next.status = code;
      st_next.flag = 1'b1;
    end

    res.status_code    = st_next.status;
    res.interrupt_flag = st_next.flag;
    res.data_byte      = st_next.data;
  end

endmodule

FILE: hw/rtl/twi_status_and_address_unit.sv
// top level of the two-wire status and address unit
//
// register-side logic of a two-wire serial controller. each request carries
// one event (control write, data write, or a host/client bus-engine event)
// and yields exactly one result with the status code, interrupt flag, data
// byte, ack reply and an optional start/stop/continue command. a request is
// captured in an input register, resolved by one level of combinational
// logic against the status state, and lands in a result register; a new
// request is taken every cycle while the result side keeps up. the status
// state is updated as the request moves into the result register, so
// back-to-back requests see each other's effects in order. configuration
// (own address, address mask, general-call enable) is written through
// cfg_we/cfg_index/cfg_data only while no request is in flight, a rule for
// the user, not enforced by the block; indexes beyond the list are ignored.
module twi_status_and_address_unit (
  input  logic             clk,
  input  logic             rst,
  twsa_req_if.sink         req,
  twsa_rsp_if.source       rsp,
  input  logic             cfg_we,
  input  logic       [1:0] cfg_index,
  input  logic       [6:0] cfg_data
);

  twsa_pkg::cfg_t    cfg;
  twsa_pkg::state_t  st;
  twsa_pkg::state_t  st_next;
  twsa_pkg::item_t   item;
  twsa_pkg::item_t   item_in;
  twsa_pkg::match_t  match;
  twsa_pkg::result_t res;
  twsa_pkg::result_t res_q;
  logic              item_valid;
  logic              rsp_valid;
  logic              advance;
  logic              fire;

  // result register frees up when empty or being taken
  assign advance   = ~rsp_valid | rsp.ready;
  assign fire      = item_valid & advance;
  assign req.ready = ~item_valid | advance;

  always_comb begin
    item_in.action                = req.action;
    item_in.byte_value            = req.byte_value;
    item_in.first_byte            = req.first_byte;
    item_in.read_not_write        = req.read_not_write;
    item_in.ack_bit               = req.ack_bit;
    item_in.host_lost_arbitration = req.host_lost_arbitration;
    item_in.enable_bit            = req.enable_bit;
    item_in.flag_clear_bit        = req.flag_clear_bit;
    item_in.ack_enable_bit        = req.ack_enable_bit;
    item_in.start_bit             = req.start_bit;
    item_in.stop_bit              = req.stop_bit;
    item_in.was_addressed         = req.was_addressed;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address         <= twsa_pkg::OWN_ADDRESS_RESET;
      cfg.address_mask        <= '0;
      cfg.general_call_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        twsa_pkg::CFG_OWN_ADDRESS:  cfg.own_address         <= cfg_data;
        twsa_pkg::CFG_ADDRESS_MASK: cfg.address_mask        <= cfg_data;
        twsa_pkg::CFG_GC_ENABLE:    cfg.general_call_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.ready) begin
      item_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item <= item_in;
    end
  end

  twsa_addr_match u_addr_match (
    .addr_rw (item.byte_value),
    .cfg     (cfg),
    .match   (match)
  );

  twsa_event_logic u_event_logic (
    .st      (st),
    .item    (item),
    .match   (match),
    .st_next (st_next),
    .res     (res)
  );

  // status state, committed as the event moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.status            <= twsa_pkg::ST_NO_STATE;
      st.flag              <= 1'b0;
      st.data              <= twsa_pkg::DATA_RESET;
      st.ack_enable        <= 1'b0;
      st.latched_ack       <= 1'b0;
      st.general_call_seen <= 1'b0;
      st.enabled           <= 1'b0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status_code    = res_q.status_code;
  assign rsp.interrupt_flag = res_q.interrupt_flag;
  assign rsp.data_byte      = res_q.data_byte;
  assign rsp.ack_reply      = res_q.ack_reply;
  assign rsp.command_valid  = res_q.command_valid;
  assign rsp.command_start  = res_q.command_start;
  assign rsp.command_stop   = res_q.command_stop;

endmodule
